>>> sv/amsup_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis move supervisor package
// Shared codes, register indexes, reset values and the configuration
// register bundle used by the supervisor and its configuration bank.
// ----------------------------------------------------------------------------
package amsup_pkg;

  // Configuration port geometry.
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 12;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_HOLD_TICKS     = 3'd0,
    CFG_BLANK_TICKS    = 3'd1,
    CFG_STALL_INTERVAL = 3'd2,
    CFG_STALL_DELTA    = 3'd3,
    CFG_MAX_Z_TARGET   = 3'd4,
    CFG_START_WINDOW   = 3'd5,
    CFG_ARRIVE_WINDOW  = 3'd6,
    CFG_TIMEOUT_MARGIN = 3'd7
  } cfg_index_t;

  // Configuration register reset values.
  localparam logic [7:0]  HOLD_TICKS_RST     = 8'd80;
  localparam logic [7:0]  BLANK_TICKS_RST    = 8'd50;
  localparam logic [7:0]  STALL_INTERVAL_RST = 8'd15;
  localparam logic [7:0]  STALL_DELTA_RST    = 8'd2;
  localparam logic [11:0] MAX_Z_TARGET_RST   = 12'd1350;
  localparam logic [7:0]  START_WINDOW_RST   = 8'd5;
  localparam logic [7:0]  ARRIVE_WINDOW_RST  = 8'd2;
  localparam logic [9:0]  TIMEOUT_MARGIN_RST = 10'd50;

  // Configuration register bundle.
  typedef struct packed {
    logic [7:0]  hold_ticks;
    logic [7:0]  blank_ticks;
    logic [7:0]  stall_interval;
    logic [7:0]  stall_delta;
    logic [11:0] max_z_target;
    logic [7:0]  start_window;
    logic [7:0]  arrive_window;
    logic [9:0]  timeout_margin;
  } cfg_t;

  // Request types.
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_ABORT = 2'd2
  } req_type_t;

  // Axis codes.
  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  // Start responses.
  typedef enum logic [2:0] {
    RESP_ACCEPTED = 3'd0,
    RESP_ALREADY  = 3'd1,
    RESP_BAD_MODE = 3'd2,
    RESP_PWR_OFF  = 3'd3,
    RESP_BUSY     = 3'd4,
    RESP_BAD_POS  = 3'd5,
    RESP_NONE     = 3'd6
  } resp_t;

  // Move events.
  typedef enum logic [2:0] {
    EVT_NONE     = 3'd0,
    EVT_ARRIVED  = 3'd1,
    EVT_ABORTED  = 3'd2,
    EVT_KEY_REL  = 3'd3,
    EVT_OBSTACLE = 3'd4,
    EVT_TIMEOUT  = 3'd5,
    EVT_FINISHED = 3'd6
  } evt_t;

  // Driver modes.
  typedef enum logic [3:0] {
    DRV_OFF     = 4'd0,
    DRV_X_LEFT  = 4'd1,
    DRV_X_RIGHT = 4'd2,
    DRV_X_SHORT = 4'd3,
    DRV_Y_HOME  = 4'd4,
    DRV_Y_FIELD = 4'd5,
    DRV_Y_SHORT = 4'd6,
    DRV_Z_UP    = 4'd7,
    DRV_Z_DOWN  = 4'd8,
    DRV_Z_SHORT = 4'd9
  } drive_t;

  // Power code for level zero, and the floor used when Z moves up.
  localparam logic [2:0] POWER_LEVEL_ZERO = 3'd7;
  localparam logic [2:0] Z_UP_FLOOR       = 3'd2;

  // Distance bands for the power level.
  localparam int BAND_7 = 1000;
  localparam int BAND_6 = 500;
  localparam int BAND_5 = 400;
  localparam int BAND_4 = 300;
  localparam int BAND_3 = 200;
  localparam int BAND_2 = 100;
  localparam int BAND_1 = 50;

  localparam logic [7:0] STALL_TICKS_MAX = 8'd255;

endpackage

>>> sv/amsup_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis move supervisor request channel
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
interface amsup_req_if #(
  parameter int POSITION_BITS = 12
);
  logic                     valid;
  logic                     ready;
  logic [1:0]               req_type;
  logic [1:0]               axis;
  logic [POSITION_BITS-1:0] target_dm;
  logic                     from_host;
  logic                     key_hold_required;
  logic [POSITION_BITS-1:0] position_dm;
  logic                     key_down;
  logic                     power_switch_on;
  logic                     in_command_mode;

  modport source (
    output valid, req_type, axis, target_dm, from_host, key_hold_required,
           position_dm, key_down, power_switch_on, in_command_mode,
    input  ready
  );
  modport sink (
    input  valid, req_type, axis, target_dm, from_host, key_hold_required,
           position_dm, key_down, power_switch_on, in_command_mode,
    output ready
  );
endinterface

>>> sv/amsup_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis move supervisor result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface amsup_res_if #(
  parameter int POSITION_BITS = 12
);
  logic                     valid;
  logic                     ready;
  logic [2:0]               response;
  logic [2:0]               move_event;
  logic [3:0]               drive_mode;
  logic [2:0]               power_code;
  logic                     report_host;
  logic [POSITION_BITS-1:0] report_position;
  logic                     busy_res;

  modport source (
    output valid, response, move_event, drive_mode, power_code, report_host,
           report_position, busy_res,
    input  ready
  );
  modport sink (
    input  valid, response, move_event, drive_mode, power_code, report_host,
           report_position, busy_res,
    output ready
  );
endinterface

>>> sv/amsup_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis move supervisor configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface amsup_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [amsup_pkg::CFG_INDEX_BITS-1:0] index;
  logic [amsup_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> sv/amsup_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis move supervisor configuration bank
// Holds the eight configuration registers and decodes write transactions.
// ----------------------------------------------------------------------------
module amsup_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  amsup_cfg_if.sink         cfg,
  output amsup_pkg::cfg_t   regs
);

  // Writes are always taken.
  assign cfg.ready = 1'b1;

  // Register bank with decode of the write index.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.hold_ticks     <= amsup_pkg::HOLD_TICKS_RST;
      regs.blank_ticks    <= amsup_pkg::BLANK_TICKS_RST;
      regs.stall_interval <= amsup_pkg::STALL_INTERVAL_RST;
      regs.stall_delta    <= amsup_pkg::STALL_DELTA_RST;
      regs.max_z_target   <= amsup_pkg::MAX_Z_TARGET_RST;
      regs.start_window   <= amsup_pkg::START_WINDOW_RST;
      regs.arrive_window  <= amsup_pkg::ARRIVE_WINDOW_RST;
      regs.timeout_margin <= amsup_pkg::TIMEOUT_MARGIN_RST;
    end else if (cfg.valid) begin
      unique case (amsup_pkg::cfg_index_t'(cfg.index))
        amsup_pkg::CFG_HOLD_TICKS:     regs.hold_ticks     <= cfg.data[7:0];
        amsup_pkg::CFG_BLANK_TICKS:    regs.blank_ticks    <= cfg.data[7:0];
        amsup_pkg::CFG_STALL_INTERVAL: regs.stall_interval <= cfg.data[7:0];
        amsup_pkg::CFG_STALL_DELTA:    regs.stall_delta    <= cfg.data[7:0];
        amsup_pkg::CFG_MAX_Z_TARGET:   regs.max_z_target   <= cfg.data[11:0];
        amsup_pkg::CFG_START_WINDOW:   regs.start_window   <= cfg.data[7:0];
        amsup_pkg::CFG_ARRIVE_WINDOW:  regs.arrive_window  <= cfg.data[7:0];
        amsup_pkg::CFG_TIMEOUT_MARGIN: regs.timeout_margin <= cfg.data[9:0];
        default: ;
      endcase
    end
  end

endmodule

>>> sv/axis_move_supervisor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis move supervisor
// Checks start requests and supervises one axis move per tick, followed by
// a motor hold phase.
// ----------------------------------------------------------------------------
// Usage:
//   req carries start, tick and abort requests; res returns exactly one
//   result per request; cfg writes the eight configuration registers and
//   is always ready. Configure only while no request is in flight.
//   A request transaction is captured in an input register; when the result
//   register can take it, the decision logic updates the supervisor state and
//   loads the result register. Throughput is one request per cycle while the
//   receiver takes results: the input register refills in the same cycle it
//   hands its item to the result register.
//   When the receiver stalls, the result register holds its transaction,
//   the input register holds one more request, and req.ready then drops.
//   Reset clears both registers, idles the supervisor, disables the driver,
//   sets the power code to level zero and restores register defaults.
// ----------------------------------------------------------------------------
module axis_move_supervisor #(
  parameter int POSITION_BITS = 12,
  parameter int TIMER_BITS    = 14
) (
  input  logic       clk,
  input  logic       rst,
  amsup_req_if.sink  req,
  amsup_res_if.source res,
  amsup_cfg_if.sink  cfg
);

  // Width wide enough for every widened compare and the timeout sum.
  localparam int WB = ((POSITION_BITS + 1 > TIMER_BITS) ? POSITION_BITS + 1 : TIMER_BITS) + 1;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

  amsup_pkg::cfg_t regs;

  amsup_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Input register.
  logic                     in_valid;
  logic [1:0]               in_req_type;
  logic [1:0]               in_axis;
  logic [POSITION_BITS-1:0] in_target;
  logic                     in_from_host;
  logic                     in_key_req;
  logic [POSITION_BITS-1:0] in_pos;
  logic                     in_key;
  logic                     in_pwr_on;
  logic                     in_cmd_mode;

  logic advance;

  assign advance   = in_valid && (!res.valid || res.ready);
  assign req.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_req_type  <= req.req_type;
      in_axis      <= req.axis;
      in_target    <= req.target_dm;
      in_from_host <= req.from_host;
      in_key_req   <= req.key_hold_required;
      in_pos       <= req.position_dm;
      in_key       <= req.key_down;
      in_pwr_on    <= req.power_switch_on;
      in_cmd_mode  <= req.in_command_mode;
    end
  end

  // Supervisor state.
  logic                     move_active, move_active_next;
  logic                     hold_phase, hold_phase_next;
  logic [1:0]               move_axis, move_axis_next;
  logic [POSITION_BITS-1:0] move_target, move_target_next;
  logic                     host_started, host_started_next;
  logic                     key_mode, key_mode_next;
  logic                     abort_pending, abort_pending_next;
  logic [TIMER_BITS-1:0]    run_ticks, run_ticks_next;
  logic [TIMER_BITS-1:0]    run_limit, run_limit_next;
  logic [7:0]               stall_ticks, stall_ticks_next;
  logic [POSITION_BITS-1:0] stall_position, stall_position_next;
  logic [2:0]               power_floor, power_floor_next;
  logic [7:0]               hold_count, hold_count_next;
  logic [3:0]               drive_reg, drive_reg_next;
  logic [2:0]               power_reg, power_reg_next;

  // Result of the current item.
  logic [2:0]               response;
  logic [2:0]               event_code;
  logic [POSITION_BITS-1:0] report_pos;

  // Shared distance terms.
  logic [POSITION_BITS-1:0] aim_target;
  logic [POSITION_BITS-1:0] span;
  logic [WB-1:0]            dist_w;
  logic                     below;
  logic [POSITION_BITS-1:0] stall_move;
  logic [WB-1:0]            limit_sum;
  logic [2:0]               band_level;
  logic [2:0]               level;
  logic [TIMER_BITS-1:0]    run_inc;
  logic [7:0]               stall_inc;
  logic [7:0]               hold_dec;

  // A start measures against its own target, a tick against the armed move.
  assign aim_target = (in_req_type == amsup_pkg::REQ_START) ? in_target : move_target;
  assign below      = aim_target < in_pos;
  assign span       = below ? (in_pos - aim_target) : (aim_target - in_pos);
  assign dist_w     = WB'(span);
  assign stall_move = (in_pos > stall_position) ? (in_pos - stall_position)
                                                : (stall_position - in_pos);
  assign limit_sum  = ((in_axis == amsup_pkg::AXIS_Z) ? (dist_w << 1) : dist_w)
                      + WB'(regs.timeout_margin);
  assign run_inc    = (run_ticks < TIMER_MAX) ? run_ticks + 1'b1 : run_ticks;
  assign stall_inc  = (stall_ticks < amsup_pkg::STALL_TICKS_MAX) ? stall_ticks + 8'd1
                                                                 : stall_ticks;
  assign hold_dec   = (hold_count != 8'd0) ? hold_count - 8'd1 : hold_count;

  // Power level from the distance band, raised to the floor.
  always_comb begin
    priority if (dist_w > WB'(amsup_pkg::BAND_7)) band_level = 3'd7;
    else if (dist_w > WB'(amsup_pkg::BAND_6)) band_level = 3'd6;
    else if (dist_w > WB'(amsup_pkg::BAND_5)) band_level = 3'd5;
    else if (dist_w > WB'(amsup_pkg::BAND_4)) band_level = 3'd4;
    else if (dist_w > WB'(amsup_pkg::BAND_3)) band_level = 3'd3;
    else if (dist_w > WB'(amsup_pkg::BAND_2)) band_level = 3'd2;
    else if (dist_w > WB'(amsup_pkg::BAND_1)) band_level = 3'd1;
    else band_level = 3'd0;
    level = (band_level < power_floor) ? power_floor : band_level;
  end

  // Decision logic for one item.
  always_comb begin
    move_active_next    = move_active;
    hold_phase_next     = hold_phase;
    move_axis_next      = move_axis;
    move_target_next    = move_target;
    host_started_next   = host_started;
    key_mode_next       = key_mode;
    abort_pending_next  = abort_pending;
    run_ticks_next      = run_ticks;
    run_limit_next      = run_limit;
    stall_ticks_next    = stall_ticks;
    stall_position_next = stall_position;
    power_floor_next    = power_floor;
    hold_count_next     = hold_count;
    drive_reg_next      = drive_reg;
    power_reg_next      = power_reg;
    response            = amsup_pkg::RESP_NONE;
    event_code          = amsup_pkg::EVT_NONE;
    report_pos          = '0;

    if (in_req_type == amsup_pkg::REQ_START) begin
      // Start checks in priority order.
      priority if (in_from_host && !in_cmd_mode) begin
        response = amsup_pkg::RESP_BAD_MODE;
      end else if (!in_pwr_on) begin
        response = amsup_pkg::RESP_PWR_OFF;
      end else if (move_active) begin
        response = amsup_pkg::RESP_BUSY;
      end else if (in_axis == amsup_pkg::AXIS_NONE ||
                   (in_axis == amsup_pkg::AXIS_Z &&
                    WB'(in_target) > WB'(regs.max_z_target))) begin
        response = amsup_pkg::RESP_BAD_POS;
      end else if (dist_w < WB'(regs.start_window)) begin
        response = amsup_pkg::RESP_ALREADY;
      end else begin
        response           = amsup_pkg::RESP_ACCEPTED;
        move_active_next   = 1'b1;
        hold_phase_next    = 1'b0;
        move_axis_next     = in_axis;
        move_target_next   = in_target;
        host_started_next  = in_from_host;
        key_mode_next      = in_key_req;
        abort_pending_next = 1'b0;
        run_ticks_next     = '0;
        power_floor_next   = '0;
        hold_count_next    = regs.hold_ticks;
        run_limit_next     = (limit_sum > WB'(TIMER_MAX)) ? TIMER_MAX
                                                          : limit_sum[TIMER_BITS-1:0];
      end
    end else if (in_req_type == amsup_pkg::REQ_ABORT) begin
      abort_pending_next = 1'b1;
    end else if (move_active && hold_phase) begin
      // Hold phase: count down unless a held key pauses it.
      if (!(key_mode && in_key)) begin
        hold_count_next = hold_dec;
        if (hold_dec == 8'd0) begin
          drive_reg_next   = amsup_pkg::DRV_OFF;
          hold_phase_next  = 1'b0;
          move_active_next = 1'b0;
          event_code       = amsup_pkg::EVT_FINISHED;
        end
      end
    end else if (move_active) begin
      // Running move.
      run_ticks_next   = run_inc;
      stall_ticks_next = stall_inc;
      priority if (abort_pending) begin
        event_code = amsup_pkg::EVT_ABORTED;
      end else if (key_mode && !in_key) begin
        event_code = amsup_pkg::EVT_KEY_REL;
      end else begin
        if (WB'(run_inc) > WB'(regs.blank_ticks)) begin
          if (stall_inc > regs.stall_interval) begin
            if (WB'(stall_move) > WB'(regs.stall_delta)) begin
              stall_ticks_next    = '0;
              stall_position_next = in_pos;
            end else begin
              event_code = amsup_pkg::EVT_OBSTACLE;
            end
          end
        end else begin
          stall_ticks_next    = '0;
          stall_position_next = in_pos;
        end
        if (event_code == amsup_pkg::EVT_NONE && run_inc > run_limit) begin
          event_code = amsup_pkg::EVT_TIMEOUT;
        end
        if (event_code == amsup_pkg::EVT_NONE) begin
          power_reg_next = amsup_pkg::POWER_LEVEL_ZERO - level;
          if (dist_w < WB'(regs.arrive_window)) begin
            event_code = amsup_pkg::EVT_ARRIVED;
            report_pos = in_pos;
          end else if (below) begin
            priority if (move_axis == amsup_pkg::AXIS_X) begin
              power_floor_next = '0;
              drive_reg_next   = amsup_pkg::DRV_X_RIGHT;
            end else if (move_axis == amsup_pkg::AXIS_Y) begin
              power_floor_next = '0;
              drive_reg_next   = amsup_pkg::DRV_Y_HOME;
            end else begin
              power_floor_next = amsup_pkg::Z_UP_FLOOR;
              drive_reg_next   = amsup_pkg::DRV_Z_UP;
            end
          end else begin
            power_floor_next = '0;
            priority if (move_axis == amsup_pkg::AXIS_X) begin
              drive_reg_next = amsup_pkg::DRV_X_LEFT;
            end else if (move_axis == amsup_pkg::AXIS_Y) begin
              drive_reg_next = amsup_pkg::DRV_Y_FIELD;
            end else begin
              drive_reg_next = amsup_pkg::DRV_Z_DOWN;
            end
          end
        end
      end
      // Any end of the move enters the hold phase with the motor shorted.
      if (event_code != amsup_pkg::EVT_NONE) begin
        hold_phase_next = 1'b1;
        priority if (move_axis == amsup_pkg::AXIS_X) begin
          drive_reg_next = amsup_pkg::DRV_X_SHORT;
        end else if (move_axis == amsup_pkg::AXIS_Y) begin
          drive_reg_next = amsup_pkg::DRV_Y_SHORT;
        end else begin
          drive_reg_next = amsup_pkg::DRV_Z_SHORT;
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      move_active    <= 1'b0;
      hold_phase     <= 1'b0;
      move_axis      <= '0;
      move_target    <= '0;
      host_started   <= 1'b0;
      key_mode       <= 1'b0;
      abort_pending  <= 1'b0;
      run_ticks      <= '0;
      run_limit      <= '0;
      stall_ticks    <= '0;
      stall_position <= '0;
      power_floor    <= '0;
      hold_count     <= '0;
      drive_reg      <= amsup_pkg::DRV_OFF;
      power_reg      <= amsup_pkg::POWER_LEVEL_ZERO;
    end else if (advance) begin
      move_active    <= move_active_next;
      hold_phase     <= hold_phase_next;
      move_axis      <= move_axis_next;
      move_target    <= move_target_next;
      host_started   <= host_started_next;
      key_mode       <= key_mode_next;
      abort_pending  <= abort_pending_next;
      run_ticks      <= run_ticks_next;
      run_limit      <= run_limit_next;
      stall_ticks    <= stall_ticks_next;
      stall_position <= stall_position_next;
      power_floor    <= power_floor_next;
      hold_count     <= hold_count_next;
      drive_reg      <= drive_reg_next;
      power_reg      <= power_reg_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.response        <= response;
      res.move_event      <= event_code;
      res.drive_mode      <= drive_reg_next;
      res.power_code      <= power_reg_next;
      res.report_host     <= (event_code >= amsup_pkg::EVT_ARRIVED &&
                              event_code <= amsup_pkg::EVT_TIMEOUT) ? host_started : 1'b0;
      res.report_position <= report_pos;
      res.busy_res        <= move_active_next;
    end
  end

  // Checks.
  a_hold_needs_move: assert property (@(posedge clk) disable iff (rst)
    hold_phase |-> move_active)
    else $error("hold phase without an active move");

  a_finish_idles: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.move_event == amsup_pkg::EVT_FINISHED |-> !res.busy_res)
    else $error("finished event reported while still busy");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> in_valid && res.valid && !res.ready)
    else $error("request channel stalled without a full pipeline");

  a_reset_clears_result: assert property (@(posedge clk)
    rst |=> !res.valid && !move_active)
    else $error("result or move survived reset");

endmodule

>>> verif/tb_axis_move_supervisor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis move supervisor testbench
// Drives start, tick and abort requests into the supervisor and checks every
// result against a cycle-free model of the move rules kept in this file.
// Directed items cover the start checks and the special cases, a long
// stationary move exercises the stall counter saturation, and random move
// sequences run under several register settings with random idling on both
// channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_axis_move_supervisor;
  import amsup_pkg::*;

  localparam int          CLK_PERIOD    = 12;
  localparam int          POS_BITS      = 12;
  localparam int          TMR_BITS      = 14;
  localparam int unsigned TIMER_MAX     = (1 << TMR_BITS) - 1;
  localparam int unsigned POS_MAX       = (1 << POS_BITS) - 1;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          LONG_HOLD_OFF = 200;
  localparam int          MAX_PRINTS    = 40;
  // Request type three has no name in the package and behaves as a tick.
  localparam logic [1:0]  REQ_SPARE     = 2'd3;

  typedef struct {
    logic [1:0]          req_type;
    axis_t               axis;
    logic [POS_BITS-1:0] target_dm;
    logic                from_host;
    logic                key_hold_required;
    logic [POS_BITS-1:0] position_dm;
    logic                key_down;
    logic                power_switch_on;
    logic                in_command_mode;
  } request_t;

  typedef struct {
    resp_t               response;
    evt_t                move_event;
    drive_t              drive_mode;
    logic [2:0]          power_code;
    logic                report_host;
    logic [POS_BITS-1:0] report_position;
    logic                busy_res;
  } move_result_t;

  logic clk = 1'b0;
  logic rst;

  amsup_req_if #(.POSITION_BITS(POS_BITS)) req_bus ();
  amsup_res_if #(.POSITION_BITS(POS_BITS)) res_bus ();
  amsup_cfg_if                             cfg_bus ();

  axis_move_supervisor #(
    .POSITION_BITS(POS_BITS),
    .TIMER_BITS   (TMR_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .res(res_bus),
    .cfg(cfg_bus)
  );

  // Clock generation.
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Model copy of the registers and the supervisor state.
  cfg_t                cfg_m;
  logic                mv_active, mv_hold, mv_host, mv_keymode, abort_flag;
  axis_t               mv_axis;
  logic [POS_BITS-1:0] mv_target, stall_pos;
  logic [TMR_BITS-1:0] run_cnt, run_lim;
  logic [7:0]          stall_cnt, hold_cnt;
  logic [2:0]          pwr_floor, power_q;
  drive_t              drive_q;

  // Stimulus side: simulated axis position and the shape of the current move.
  int unsigned phys_pos;
  int          stuck_at;
  int unsigned step_max;
  int unsigned move_ticks;

  move_result_t pending_results[$];
  int unsigned  mismatch_count = 0;
  bit           src_idle_on    = 1'b1;
  bit           sink_idle_on   = 1'b1;
  bit           hold_off_req   = 1'b0;

  function automatic int unsigned pos_distance(input int unsigned a, input int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Applies one request to the model state and returns the result it causes.
  function automatic move_result_t predict_move_result(input request_t rq);
    move_result_t r;
    evt_t         ev;
    int unsigned  span;
    int unsigned  lim;
    int unsigned  lvl;
    logic         below;
    r.response        = RESP_NONE;
    r.report_position = '0;
    ev                = EVT_NONE;
    if (rq.req_type == REQ_START) begin
      span = pos_distance(rq.position_dm, rq.target_dm);
      if (rq.from_host && !rq.in_command_mode) begin
        r.response = RESP_BAD_MODE;
      end else if (!rq.power_switch_on) begin
        r.response = RESP_PWR_OFF;
      end else if (mv_active) begin
        r.response = RESP_BUSY;
      end else if (rq.axis == AXIS_NONE ||
                   (rq.axis == AXIS_Z && rq.target_dm > cfg_m.max_z_target)) begin
        r.response = RESP_BAD_POS;
      end else if (span < cfg_m.start_window) begin
        r.response = RESP_ALREADY;
      end else begin
        lim        = ((rq.axis == AXIS_Z) ? 2 * span : span) + cfg_m.timeout_margin;
        r.response = RESP_ACCEPTED;
        mv_active  = 1'b1;
        mv_hold    = 1'b0;
        mv_axis    = rq.axis;
        mv_target  = rq.target_dm;
        mv_host    = rq.from_host;
        mv_keymode = rq.key_hold_required;
        abort_flag = 1'b0;
        run_cnt    = '0;
        pwr_floor  = '0;
        hold_cnt   = cfg_m.hold_ticks;
        run_lim    = (lim > TIMER_MAX) ? TMR_BITS'(TIMER_MAX) : TMR_BITS'(lim);
      end
    end else if (rq.req_type == REQ_ABORT) begin
      abort_flag = 1'b1;
    end else if (mv_active && mv_hold) begin
      // Hold phase: in key mode the count waits while a key is pressed.
      if (!(mv_keymode && rq.key_down)) begin
        if (hold_cnt > 0) hold_cnt--;
        if (hold_cnt == 0) begin
          drive_q   = DRV_OFF;
          mv_hold   = 1'b0;
          mv_active = 1'b0;
          ev        = EVT_FINISHED;
        end
      end
    end else if (mv_active) begin
      span  = pos_distance(mv_target, rq.position_dm);
      below = (mv_target < rq.position_dm);
      if (run_cnt < TIMER_MAX) run_cnt++;
      if (stall_cnt < STALL_TICKS_MAX) stall_cnt++;
      if (abort_flag) begin
        ev = EVT_ABORTED;
      end else if (mv_keymode && !rq.key_down) begin
        ev = EVT_KEY_REL;
      end else begin
        // Obstacle check only after the blanking ticks.
        if (run_cnt > cfg_m.blank_ticks) begin
          if (stall_cnt > cfg_m.stall_interval) begin
            if (pos_distance(rq.position_dm, stall_pos) > cfg_m.stall_delta) begin
              stall_cnt = '0;
              stall_pos = rq.position_dm;
            end else begin
              ev = EVT_OBSTACLE;
            end
          end
        end else begin
          stall_cnt = '0;
          stall_pos = rq.position_dm;
        end
        if (ev == EVT_NONE && run_cnt > run_lim) ev = EVT_TIMEOUT;
        if (ev == EVT_NONE) begin
          if (span > BAND_7) lvl = 7;
          else if (span > BAND_6) lvl = 6;
          else if (span > BAND_5) lvl = 5;
          else if (span > BAND_4) lvl = 4;
          else if (span > BAND_3) lvl = 3;
          else if (span > BAND_2) lvl = 2;
          else if (span > BAND_1) lvl = 1;
          else lvl = 0;
          if (lvl < pwr_floor) lvl = pwr_floor;
          power_q = POWER_LEVEL_ZERO - 3'(lvl);
          if (span < cfg_m.arrive_window) begin
            ev                = EVT_ARRIVED;
            r.report_position = rq.position_dm;
          end else if (below) begin
            case (mv_axis)
              AXIS_X: begin
                pwr_floor = '0;
                drive_q   = DRV_X_RIGHT;
              end
              AXIS_Y: begin
                pwr_floor = '0;
                drive_q   = DRV_Y_HOME;
              end
              default: begin
                pwr_floor = Z_UP_FLOOR;
                drive_q   = DRV_Z_UP;
              end
            endcase
          end else begin
            pwr_floor = '0;
            case (mv_axis)
              AXIS_X:  drive_q = DRV_X_LEFT;
              AXIS_Y:  drive_q = DRV_Y_FIELD;
              default: drive_q = DRV_Z_DOWN;
            endcase
          end
        end
      end
      // Any ending event shorts the motor of the moving axis.
      if (ev != EVT_NONE) begin
        case (mv_axis)
          AXIS_X:  drive_q = DRV_X_SHORT;
          AXIS_Y:  drive_q = DRV_Y_SHORT;
          default: drive_q = DRV_Z_SHORT;
        endcase
        mv_hold = 1'b1;
      end
    end
    r.move_event  = ev;
    r.drive_mode  = drive_q;
    r.power_code  = power_q;
    r.report_host = (ev != EVT_NONE && ev != EVT_FINISHED) ? mv_host : 1'b0;
    r.busy_res    = mv_active;
    return r;
  endfunction

  function automatic request_t make_request(
    input logic [1:0]  kind,
    input axis_t       ax,
    input int unsigned target,
    input logic        host,
    input logic        keyreq,
    input int unsigned pos,
    input logic        key,
    input logic        pwr,
    input logic        cmd
  );
    request_t rq;
    rq.req_type          = kind;
    rq.axis              = ax;
    rq.target_dm         = POS_BITS'(target);
    rq.from_host         = host;
    rq.key_hold_required = keyreq;
    rq.position_dm       = POS_BITS'(pos);
    rq.key_down          = key;
    rq.power_switch_on   = pwr;
    rq.in_command_mode   = cmd;
    return rq;
  endfunction

  // Picks the next request from the model state: mostly well-formed moves
  // (start, ticks approaching the target, hold ticks), the rest noise.
  function automatic request_t next_request();
    request_t    rq;
    int unsigned roll;
    int unsigned d;
    int unsigned step;
    int unsigned pos;
    rq.req_type          = 2'($urandom_range(0, 3));
    rq.axis              = axis_t'($urandom_range(0, 3));
    rq.target_dm         = POS_BITS'($urandom);
    rq.from_host         = 1'($urandom);
    rq.key_hold_required = 1'($urandom);
    rq.position_dm       = POS_BITS'($urandom);
    rq.key_down          = 1'($urandom);
    rq.power_switch_on   = 1'($urandom);
    rq.in_command_mode   = 1'($urandom);
    roll                 = $urandom_range(0, 99);
    if (!mv_active) begin
      if (roll < 80) begin
        rq.req_type          = REQ_START;
        rq.axis              = ($urandom_range(0, 19) == 0) ? AXIS_NONE
                                                            : axis_t'($urandom_range(0, 2));
        rq.power_switch_on   = ($urandom_range(0, 9) != 0);
        rq.in_command_mode   = ($urandom_range(0, 9) != 0);
        rq.key_hold_required = ($urandom_range(0, 3) == 0);
        d   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, POS_MAX) : $urandom_range(0, 300);
        pos = rq.position_dm;
        if ($urandom_range(0, 1) && pos >= d) rq.target_dm = POS_BITS'(pos - d);
        else if (pos + d <= POS_MAX) rq.target_dm = POS_BITS'(pos + d);
        else if (pos >= d) rq.target_dm = POS_BITS'(pos - d);
      end
      if (rq.req_type == REQ_START) begin
        phys_pos   = rq.position_dm;
        stuck_at   = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 40)) : -1;
        step_max   = $urandom_range(1, 24);
        move_ticks = 0;
      end
    end else if (!mv_hold) begin
      if (roll < 88) begin
        rq.req_type = (roll < 4) ? REQ_SPARE : REQ_TICK;
        move_ticks++;
        if (stuck_at >= 0 && move_ticks > stuck_at) step = 0;
        else step = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, step_max);
        d = pos_distance(phys_pos, mv_target);
        if (step >= d) phys_pos = mv_target;
        else if (mv_target > phys_pos) phys_pos = phys_pos + step;
        else phys_pos = phys_pos - step;
        rq.position_dm = POS_BITS'(phys_pos);
        if (mv_keymode) rq.key_down = ($urandom_range(0, 39) != 0);
      end else if (roll < 93) begin
        rq.req_type = REQ_ABORT;
      end else if (roll < 97) begin
        rq.req_type        = REQ_START;
        rq.power_switch_on = 1'b1;
      end
    end else begin
      if (roll < 90) begin
        rq.req_type = REQ_TICK;
        rq.key_down = ($urandom_range(0, 2) == 0);
      end
    end
    return rq;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) begin
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
    end
  endtask

  // Offers one request, waits for its transaction and records the expected result.
  task automatic send_item(input request_t rq);
    int unsigned gap;
    gap = 0;
    if (src_idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      @(negedge clk);
      req_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_bus.valid             <= 1'b1;
    req_bus.req_type          <= rq.req_type;
    req_bus.axis              <= rq.axis;
    req_bus.target_dm         <= rq.target_dm;
    req_bus.from_host         <= rq.from_host;
    req_bus.key_hold_required <= rq.key_hold_required;
    req_bus.position_dm       <= rq.position_dm;
    req_bus.key_down          <= rq.key_down;
    req_bus.power_switch_on   <= rq.power_switch_on;
    req_bus.in_command_mode   <= rq.in_command_mode;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    pending_results.push_back(predict_move_result(rq));
  endtask

  // Stops offering requests and waits until every expected result is back.
  task automatic settle_idle();
    @(negedge clk);
    req_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input int unsigned value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= CFG_DATA_BITS'(value);
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    case (idx)
      CFG_HOLD_TICKS:     cfg_m.hold_ticks     = 8'(value);
      CFG_BLANK_TICKS:    cfg_m.blank_ticks    = 8'(value);
      CFG_STALL_INTERVAL: cfg_m.stall_interval = 8'(value);
      CFG_STALL_DELTA:    cfg_m.stall_delta    = 8'(value);
      CFG_MAX_Z_TARGET:   cfg_m.max_z_target   = 12'(value);
      CFG_START_WINDOW:   cfg_m.start_window   = 8'(value);
      CFG_ARRIVE_WINDOW:  cfg_m.arrive_window  = 8'(value);
      default:            cfg_m.timeout_margin = 10'(value);
    endcase
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic apply_config(input cfg_t c);
    settle_idle();
    write_reg(CFG_HOLD_TICKS, c.hold_ticks);
    write_reg(CFG_BLANK_TICKS, c.blank_ticks);
    write_reg(CFG_STALL_INTERVAL, c.stall_interval);
    write_reg(CFG_STALL_DELTA, c.stall_delta);
    write_reg(CFG_MAX_Z_TARGET, c.max_z_target);
    write_reg(CFG_START_WINDOW, c.start_window);
    write_reg(CFG_ARRIVE_WINDOW, c.arrive_window);
    write_reg(CFG_TIMEOUT_MARGIN, c.timeout_margin);
  endtask

  // Ends any move in progress: abort it, then tick through the hold phase.
  task automatic finish_move();
    if (mv_active && !mv_hold) begin
      send_item(make_request(REQ_ABORT, AXIS_X, 0, 0, 0, 0, 0, 1, 1));
    end
    while (mv_active) begin
      send_item(make_request(REQ_TICK, AXIS_X, 0, 0, 0, phys_pos, 0, 1, 1));
    end
  endtask

  // Sends random requests until n of them reached an active move or a start.
  task automatic run_random(input int unsigned n);
    int unsigned counted;
    bit          useful;
    request_t    rq;
    counted = 0;
    while (counted < n) begin
      rq     = next_request();
      useful = mv_active || (rq.req_type == REQ_START);
      send_item(rq);
      if (useful) counted++;
    end
  endtask

  // Start checks in priority order, arrival, key release, hold waits, abort.
  task automatic test_directed();
    write_reg(CFG_HOLD_TICKS, 3);
    send_item(make_request(REQ_TICK, AXIS_X, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_request(REQ_SPARE, AXIS_NONE, POS_MAX, 1, 1, POS_MAX, 1, 1, 1));
    send_item(make_request(REQ_ABORT, AXIS_X, 0, 0, 0, 0, 0, 1, 1));
    send_item(make_request(REQ_START, AXIS_X, 500, 1, 0, 0, 0, 0, 0));
    send_item(make_request(REQ_START, AXIS_X, 500, 0, 0, 0, 0, 0, 0));
    send_item(make_request(REQ_START, AXIS_NONE, 500, 0, 0, 0, 0, 1, 0));
    send_item(make_request(REQ_START, AXIS_Z, POS_MAX, 0, 0, 0, 0, 1, 1));
    send_item(make_request(REQ_START, AXIS_X, 100, 0, 0, 104, 0, 1, 1));
    send_item(make_request(REQ_START, AXIS_X, POS_MAX, 1, 0, 0, 0, 1, 1));
    send_item(make_request(REQ_START, AXIS_Y, 2000, 0, 0, 0, 0, 1, 1));
    send_item(make_request(REQ_TICK, AXIS_X, 0, 0, 0, 0, 0, 1, 1));
    send_item(make_request(REQ_TICK, AXIS_X, 0, 0, 0, POS_MAX - 1, 0, 1, 1));
    // Abort during hold only sets the pending flag.
    send_item(make_request(REQ_ABORT, AXIS_X, 0, 0, 0, 0, 0, 1, 1));
    repeat (3) send_item(make_request(REQ_TICK, AXIS_X, 0, 0, 0, 0, 0, 1, 1));
    // Key mode move on Y, released key, and a hold count that waits for the key.
    send_item(make_request(REQ_START, AXIS_Y, 0, 0, 1, 300, 1, 1, 1));
    send_item(make_request(REQ_TICK, AXIS_X, 0, 0, 0, 290, 1, 1, 1));
    send_item(make_request(REQ_TICK, AXIS_X, 0, 0, 0, 280, 0, 1, 1));
    send_item(make_request(REQ_TICK, AXIS_X, 0, 0, 0, 280, 1, 1, 1));
    repeat (3) send_item(make_request(REQ_TICK, AXIS_X, 0, 0, 0, 280, 0, 1, 1));
    // Z at the largest target, moving up with its power floor, then aborted.
    send_item(make_request(REQ_START, AXIS_Z, MAX_Z_TARGET_RST, 0, 0, 0, 0, 1, 1));
    send_item(make_request(REQ_TICK, AXIS_X, 0, 0, 0, 1400, 0, 1, 1));
    send_item(make_request(REQ_TICK, AXIS_X, 0, 0, 0, 1380, 0, 1, 1));
    send_item(make_request(REQ_ABORT, AXIS_X, 0, 0, 0, 0, 0, 1, 1));
    send_item(make_request(REQ_TICK, AXIS_X, 0, 0, 0, 1370, 0, 1, 1));
  endtask

  // A motionless move keeps the stall counter saturated at its maximum; a
  // lower interval then sees the saturated count on the very next tick.
  task automatic test_stall_saturation();
    finish_move();
    settle_idle();
    write_reg(CFG_BLANK_TICKS, 0);
    write_reg(CFG_STALL_INTERVAL, 255);
    write_reg(CFG_TIMEOUT_MARGIN, 100);
    write_reg(CFG_HOLD_TICKS, 1);
    send_item(make_request(REQ_START, AXIS_X, 1250, 0, 0, 1000, 0, 1, 1));
    repeat (270) send_item(make_request(REQ_TICK, AXIS_X, 0, 0, 0, 1000, 0, 1, 1));
    settle_idle();
    write_reg(CFG_STALL_INTERVAL, 254);
    repeat (2) send_item(make_request(REQ_TICK, AXIS_X, 0, 0, 0, 1000, 0, 1, 1));
  endtask

  // Random moves under reset values, all minimums, all maximums and random sets.
  task automatic test_config_sweep();
    cfg_t c;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          c.hold_ticks     = HOLD_TICKS_RST;
          c.blank_ticks    = BLANK_TICKS_RST;
          c.stall_interval = STALL_INTERVAL_RST;
          c.stall_delta    = STALL_DELTA_RST;
          c.max_z_target   = MAX_Z_TARGET_RST;
          c.start_window   = START_WINDOW_RST;
          c.arrive_window  = ARRIVE_WINDOW_RST;
          c.timeout_margin = TIMEOUT_MARGIN_RST;
        end
        1: begin
          c.hold_ticks     = 8'd1;
          c.blank_ticks    = '0;
          c.stall_interval = '0;
          c.stall_delta    = '0;
          c.max_z_target   = '0;
          c.start_window   = '0;
          c.arrive_window  = '0;
          c.timeout_margin = '0;
        end
        2: begin
          c.hold_ticks     = '1;
          c.blank_ticks    = '1;
          c.stall_interval = '1;
          c.stall_delta    = '1;
          c.max_z_target   = '1;
          c.start_window   = '1;
          c.arrive_window  = '1;
          c.timeout_margin = '1;
        end
        default: begin
          c.hold_ticks     = 8'($urandom_range(1, 8));
          c.blank_ticks    = 8'($urandom_range(0, 60));
          c.stall_interval = 8'($urandom_range(0, 30));
          c.stall_delta    = 8'($urandom_range(0, 6));
          c.max_z_target   = 12'($urandom_range(0, POS_MAX));
          c.start_window   = 8'($urandom_range(0, 20));
          c.arrive_window  = 8'($urandom_range(0, 10));
          c.timeout_margin = 10'($urandom_range(0, 200));
        end
      endcase
      apply_config(c);
      run_random(40);
    end
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    src_idle_on  = 1'b0;
    hold_off_req = 1'b1;
    repeat (30) send_item(next_request());
    src_idle_on = 1'b1;
  endtask

  // Last stretch at full rate on both sides.
  task automatic test_full_rate();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    run_random(60);
  endtask

  // Receiver ready: random stall bursts, plus the long hold-off on request.
  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        res_bus.ready <= 1'b0;
        repeat (LONG_HOLD_OFF - 1) @(negedge clk);
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        res_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  // Result checker: each result transaction against the oldest expectation.
  always @(posedge clk) begin
    move_result_t want;
    if (!rst && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected", res_bus.move_event, 0);
      end else begin
        want = pending_results.pop_front();
        if (res_bus.response !== want.response)
          report_mismatch("response", res_bus.response, want.response);
        if (res_bus.move_event !== want.move_event)
          report_mismatch("move_event", res_bus.move_event, want.move_event);
        if (res_bus.drive_mode !== want.drive_mode)
          report_mismatch("drive_mode", res_bus.drive_mode, want.drive_mode);
        if (res_bus.power_code !== want.power_code)
          report_mismatch("power_code", res_bus.power_code, want.power_code);
        if (res_bus.report_host !== want.report_host)
          report_mismatch("report_host", res_bus.report_host, want.report_host);
        if (res_bus.report_position !== want.report_position)
          report_mismatch("report_position", res_bus.report_position,
                          want.report_position);
        if (res_bus.busy_res !== want.busy_res)
          report_mismatch("busy_res", res_bus.busy_res, want.busy_res);
      end
    end
  end

  // Run limit.
  initial begin
    #(10_000_000);
    $display("simulation failed");
    $finish;
  end

  // Main sequence.
  initial begin
    rst                       = 1'b1;
    req_bus.valid             = 1'b0;
    req_bus.req_type          = REQ_TICK;
    req_bus.axis              = AXIS_X;
    req_bus.target_dm         = '0;
    req_bus.from_host         = 1'b0;
    req_bus.key_hold_required = 1'b0;
    req_bus.position_dm       = '0;
    req_bus.key_down          = 1'b0;
    req_bus.power_switch_on   = 1'b0;
    req_bus.in_command_mode   = 1'b0;
    cfg_bus.valid             = 1'b0;
    cfg_bus.index             = CFG_HOLD_TICKS;
    cfg_bus.data              = '0;

    // Model state after reset.
    cfg_m.hold_ticks     = HOLD_TICKS_RST;
    cfg_m.blank_ticks    = BLANK_TICKS_RST;
    cfg_m.stall_interval = STALL_INTERVAL_RST;
    cfg_m.stall_delta    = STALL_DELTA_RST;
    cfg_m.max_z_target   = MAX_Z_TARGET_RST;
    cfg_m.start_window   = START_WINDOW_RST;
    cfg_m.arrive_window  = ARRIVE_WINDOW_RST;
    cfg_m.timeout_margin = TIMEOUT_MARGIN_RST;
    mv_active            = 1'b0;
    mv_hold              = 1'b0;
    mv_axis              = AXIS_X;
    mv_target            = '0;
    mv_host              = 1'b0;
    mv_keymode           = 1'b0;
    abort_flag           = 1'b0;
    run_cnt              = '0;
    run_lim              = '0;
    stall_cnt            = '0;
    stall_pos            = '0;
    pwr_floor            = '0;
    hold_cnt             = '0;
    drive_q              = DRV_OFF;
    power_q              = POWER_LEVEL_ZERO;
    phys_pos             = 0;
    stuck_at             = -1;
    step_max             = 1;
    move_ticks           = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_stall_saturation();
    test_config_sweep();
    test_backpressure();
    test_full_rate();

    settle_idle();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
